### rtl/core/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and codes for the LFU cache table and its slot cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // default geometry
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_COUNT_BITS  = 16;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation requested by an input item
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // update broadcast to the cells at the end of a scan
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_USE    = 2'd1,
    OP_INSERT = 2'd2
  } upd_op_t;

endpackage

### rtl/core/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One cache slot. Holds valid, key, value, use count and recency rank, folds
// its own state into the scan item passing by, and applies the update command.
// ----------------------------------------------------------------------------
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int  IDX         = 0,
  parameter int  MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int  COUNT_BITS  = DEF_COUNT_BITS,
  parameter type scan_t      = logic,
  parameter type cmd_t       = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  scan_t scan_in,
  output scan_t scan_out,
  input  cmd_t  cmd
);

  localparam int IDX_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_BITS = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic                  valid;
  logic [KEY_W-1:0]      key;
  logic [DATA_W-1:0]     data;
  logic [COUNT_BITS-1:0] count;
  logic [IDX_BITS-1:0]   rank;

  scan_t scan_next;
  logic  is_tgt;

  // fold this slot into the passing scan item
  always_comb begin
    scan_next = scan_in;
    if (valid) begin
      scan_next.used = scan_in.used + USED_BITS'(1);
      if (!scan_in.found && key == scan_in.key) begin
        scan_next.found = 1'b1;
        scan_next.fidx  = MY_IDX;
        scan_next.fdata = data;
        scan_next.frank = rank;
      end
      // lowest count, oldest on a tie
      if (!scan_in.vic_v || count < scan_in.vic_cnt ||
          (count == scan_in.vic_cnt && rank > scan_in.vic_rank)) begin
        scan_next.vic_v    = 1'b1;
        scan_next.vic_idx  = MY_IDX;
        scan_next.vic_cnt  = count;
        scan_next.vic_rank = rank;
        scan_next.vic_key  = key;
      end
    end else if (!scan_in.free_v) begin
      scan_next.free_v   = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
  end

  // scan stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.vld <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

  assign is_tgt = (cmd.tgt == MY_IDX);

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_USE: begin
          if (is_tgt) begin
            rank <= '0;
            if (count != '1) count <= count + COUNT_BITS'(1);
            if (cmd.wr_data) data <= cmd.data;
          end else if (valid && rank < cmd.rref) begin
            rank <= rank + IDX_BITS'(1);
          end
        end
        OP_INSERT: begin
          if (is_tgt) begin
            valid <= 1'b1;
            key   <= cmd.key;
            data  <= cmd.data;
            count <= COUNT_BITS'(1);
            rank  <= '0;
          end else if (valid && (!cmd.evict || rank < cmd.rref)) begin
            rank <= rank + IDX_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// One item is handled at a time. A scan item walks the row of slot cells, one
// cell per cycle, collecting the key match, the first free slot, the occupancy
// and the eviction candidate; the result is then latched and the update is
// broadcast to all cells together, once the output register can take the result.
// The result sits in an output register, so the next item can be taken while a
// result still waits. Reset empties all slots; capacity_in_use resets to 16 and
// may be written only when idle.
// ----------------------------------------------------------------------------
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata,      // capacity_in_use
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // key [31:0], value [63:32]
  input  logic                 s_axis_tuser,   // kind
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // read_value [31:0], evicted_key [63:32]
  output logic [1:0]           m_axis_tuser    // hit [0], evicted [1]
);

  localparam int IDX_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_BITS = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic                  vld;
    logic [KEY_W-1:0]      key;
    logic                  found;
    logic [IDX_BITS-1:0]   fidx;
    logic [DATA_W-1:0]     fdata;
    logic [IDX_BITS-1:0]   frank;
    logic                  free_v;
    logic [IDX_BITS-1:0]   free_idx;
    logic [USED_BITS-1:0]  used;
    logic                  vic_v;
    logic [IDX_BITS-1:0]   vic_idx;
    logic [COUNT_BITS-1:0] vic_cnt;
    logic [IDX_BITS-1:0]   vic_rank;
    logic [KEY_W-1:0]      vic_key;
  } scan_t;

  typedef struct packed {
    upd_op_t               op;
    logic                  wr_data;
    logic                  evict;
    logic [IDX_BITS-1:0]   tgt;
    logic [IDX_BITS-1:0]   rref;
    logic [KEY_W-1:0]      key;
    logic [DATA_W-1:0]     data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  cap;
  logic              op_kind;
  logic [KEY_W-1:0]  op_key;
  logic [DATA_W-1:0] op_val;
  logic              start_vld;
  scan_t             res;

  scan_t chain [MAX_ENTRIES+1];
  cmd_t  cmd;
  cmd_t  cmd_bus;

  logic              in_fire;
  logic              commit;
  logic              cap_zero;
  logic              full;
  logic [31:0]       cap_eff;
  logic              r_hit;
  logic [DATA_W-1:0] r_val;
  logic              r_ev;
  logic [KEY_W-1:0]  r_ekey;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  // head of the cell row: fresh scan item
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = start_vld;
    chain[0].key = op_key;
  end

  // row of slot cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .IDX         (i),
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS),
      .scan_t      (scan_t),
      .cmd_t       (cmd_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .cmd      (cmd_bus)
    );
  end

  // decision from the finished scan
  assign cap_zero = (cap == '0);
  assign cap_eff  = (32'(cap) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(cap);
  assign full     = 32'(res.used) >= cap_eff;

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.key     = op_key;
    cmd.data    = op_val;
    r_hit       = 1'b0;
    r_val       = '0;
    r_ev        = 1'b0;
    r_ekey      = '0;
    if (op_kind == KIND_GET) begin
      if (res.found) begin
        r_hit    = 1'b1;
        r_val    = res.fdata;
        cmd.op   = OP_USE;
        cmd.tgt  = res.fidx;
        cmd.rref = res.frank;
      end
    end else if (!cap_zero) begin
      if (res.found) begin
        r_hit       = 1'b1;
        r_val       = res.fdata;
        cmd.op      = OP_USE;
        cmd.wr_data = 1'b1;
        cmd.tgt     = res.fidx;
        cmd.rref    = res.frank;
      end else if (full && res.vic_v) begin
        r_ev      = 1'b1;
        r_ekey    = res.vic_key;
        cmd.op    = OP_INSERT;
        cmd.evict = 1'b1;
        cmd.tgt   = res.vic_idx;
        cmd.rref  = res.vic_rank;
      end else if (res.free_v) begin
        cmd.op  = OP_INSERT;
        cmd.tgt = res.free_idx;
      end
    end
  end

  // cells see the update only in the commit cycle
  always_comb begin
    cmd_bus = cmd;
    if (!commit) cmd_bus.op = OP_NONE;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start_vld <= 1'b0;
    end else begin
      start_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            start_vld <= 1'b1;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[MAX_ENTRIES].vld) state <= ST_DONE;
        end
        ST_DONE: begin
          if (commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item and scan result capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_kind <= s_axis_tuser;
      op_key  <= s_axis_tdata[KEY_W-1:0];
      op_val  <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
    end
    if (state == ST_SCAN && chain[MAX_ENTRIES].vld) begin
      res <= chain[MAX_ENTRIES];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {r_ekey, r_val};
      m_axis_tuser <= {r_ev, r_hit};
    end
  end

endmodule

### tb/lfu_cache_table_checker.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_checker
// Watches the configuration port and both streams of the LFU cache table,
// keeps its own copy of the slot store and compares every result item with
// the outcome predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module lfu_cache_table_checker
  import lfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // key [31:0], value [63:32]
  input  logic              s_axis_tuser,   // kind
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [63:0]       m_axis_tdata,   // read_value [31:0], evicted_key [63:32]
  input  logic [1:0]        m_axis_tuser,   // hit [0], evicted [1]
  output int                failures,
  output int                pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = DEF_MAX_ENTRIES;
  localparam int USE_W   = DEF_COUNT_BITS;
  localparam int RANK_W  = $clog2(DEF_MAX_ENTRIES);
  localparam logic [USE_W-1:0] USE_MAX = '1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } access_result_t;

  // shadow copy of the slot store
  logic              line_valid [ENTRIES];
  logic [KEY_W-1:0]  line_key   [ENTRIES];
  logic [DATA_W-1:0] line_data  [ENTRIES];
  logic [USE_W-1:0]  line_uses  [ENTRIES];
  logic [RANK_W-1:0] line_rank  [ENTRIES];
  logic [CAP_W-1:0]  cap_setting;

  access_result_t outcomes_due[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  // a hit: bump the use count and move the line to the front
  function automatic void touch_line(int s);
    logic [RANK_W-1:0] r;
    r = line_rank[s];
    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j] && line_rank[j] < r) line_rank[j]++;
    line_rank[s] = '0;
    if (line_uses[s] != USE_MAX) line_uses[s]++;
  endfunction

  // outcome of one get or put, updating the shadow store as the block should
  function automatic access_result_t predict_access(logic kind, logic [KEY_W-1:0] key,
                                                    logic [DATA_W-1:0] value);
    access_result_t res;
    int found, free_idx, victim, occupied, cap;
    logic [RANK_W-1:0] vrank;
    res      = '0;
    found    = -1;
    free_idx = -1;
    victim   = -1;
    occupied = 0;
    cap      = (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);

    for (int j = 0; j < ENTRIES; j++)
      if (found < 0 && line_valid[j] && line_key[j] == key) found = j;

    if (kind == KIND_GET) begin
      if (found >= 0) begin
        res.hit        = 1'b1;
        res.read_value = line_data[found];
        touch_line(found);
      end
      return res;
    end

    // zero capacity: puts are dropped
    if (cap == 0) return res;

    if (found >= 0) begin
      res.hit        = 1'b1;
      res.read_value = line_data[found];
      touch_line(found);
      line_data[found] = value;
      return res;
    end

    for (int j = 0; j < ENTRIES; j++) begin
      if (line_valid[j]) occupied++;
      else if (free_idx < 0) free_idx = j;
    end

    // full (or over-full after a lowered capacity): evict one LFU line, LRU on a tie
    if (occupied >= cap) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (line_valid[j] &&
            (victim < 0 || line_uses[j] < line_uses[victim] ||
             (line_uses[j] == line_uses[victim] && line_rank[j] > line_rank[victim])))
          victim = j;
      end
      if (victim >= 0) begin
        vrank               = line_rank[victim];
        res.evicted         = 1'b1;
        res.evicted_key     = line_key[victim];
        line_valid[victim]  = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
          if (line_valid[j] && line_rank[j] > vrank) line_rank[j]--;
        free_idx = victim;
      end
    end

    if (free_idx < 0) return res;

    for (int j = 0; j < ENTRIES; j++)
      if (line_valid[j]) line_rank[j]++;
    line_valid[free_idx] = 1'b1;
    line_key[free_idx]   = key;
    line_data[free_idx]  = value;
    line_uses[free_idx]  = USE_W'(1);
    line_rank[free_idx]  = '0;
    return res;
  endfunction

  // sample both channels at the rising edge; requests are predicted first
  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      cap_setting = CAP_RESET;
      for (int j = 0; j < ENTRIES; j++) line_valid[j] = 1'b0;
    end else begin
      if (cfg_we) cap_setting = cfg_wdata;

      if (s_axis_tvalid && s_axis_tready)
        outcomes_due.push_back(predict_access(s_axis_tuser, s_axis_tdata[31:0],
                                              s_axis_tdata[63:32]));

      if (m_axis_tvalid && m_axis_tready) begin
        if (outcomes_due.size() == 0) begin
          $error("result item with no request outstanding");
          failures++;
        end else begin
          want = outcomes_due.pop_front();
          if (m_axis_tuser[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser[0]);
            failures++;
          end
          if (m_axis_tdata[31:0] !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, m_axis_tdata[31:0]);
            failures++;
          end
          if (m_axis_tuser[1] !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, m_axis_tuser[1]);
            failures++;
          end
          if (m_axis_tdata[63:32] !== want.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want.evicted_key,
                   m_axis_tdata[63:32]);
            failures++;
          end
        end
      end
    end
    pending = outcomes_due.size();
  end

endmodule

### tb/tb_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_table
// Stimulus and verdict for the LFU cache table: a directed opening over the
// field extremes and capacity corner cases, then phases of random gets and
// puts on small hot key pools at several capacities, with random gaps on
// both streams. Checking is done by lfu_cache_table_checker.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;

  import lfu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SETTLE_TICKS = 24;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;   // key [31:0], value [63:32]
  logic              s_axis_tuser = KIND_GET;   // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;        // read_value [31:0], evicted_key [63:32]
  logic [1:0]        m_axis_tuser;        // hit [0], evicted [1]

  int                failures;
  int                pending;
  int                cycle_count = 0;
  bit                steady = 1'b0;
  logic [KEY_W-1:0]  key_pool[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lfu_cache_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lfu_cache_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures      (failures),
    .pending       (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one; none in steady stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // one request item; entered and left at a falling edge
  task automatic send_op(input logic kind, input logic [KEY_W-1:0] key,
                         input logic [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, key};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // capacity changes only once the block has gone quiet
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    repeat (SETTLE_TICKS) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // a small key pool with the extremes in it; the front quarter is kept hot
  task automatic random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                              input int pool_n, input bit calm);
    logic [KEY_W-1:0] key;
    int               pick;
    set_capacity(cap);
    steady = calm;
    key_pool = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    while (key_pool.size() < pool_n) key_pool.push_back($urandom());
    key_pool.shuffle();
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        key = $urandom();
      end else begin
        if ($urandom_range(0, 1) == 0) pick = $urandom_range(0, (pool_n + 3) / 4 - 1);
        else pick = $urandom_range(0, pool_n - 1);
        key = key_pool[pick];
      end
      send_op($urandom_range(0, 1) ? KIND_PUT : KIND_GET, key, pick_value());
      if ($urandom_range(0, 59) == 0) drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, update of a present key, all-ones stored value
    send_op(KIND_GET, 32'h0000_0000, 32'h1234_5678);
    send_op(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_op(KIND_PUT, 32'h8000_0000, 32'h0000_0000);
    send_op(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);

    // capacity below occupancy: one eviction per put of a new key
    set_capacity(CAP_W'(1));
    send_op(KIND_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
    send_op(KIND_PUT, 32'hFFFF_FFFF, 32'h5555_5555);
    send_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(KIND_PUT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);

    // zero capacity: puts dropped, gets still see what is left
    set_capacity(CAP_W'(0));
    send_op(KIND_PUT, 32'h0000_AAAA, 32'h0000_0001);
    send_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(KIND_GET, 32'h0000_AAAA, 32'h0000_0000);
    send_op(KIND_PUT, 32'hFFFF_FFFF, 32'h0BAD_F00D);

    // random phases over a range of capacities, above the slot count included
    random_phase(CAP_W'(16), 110, 24, 1'b0);
    random_phase(CAP_W'(31), 60, 22, 1'b1);
    random_phase(CAP_W'(1), 40, 4, 1'b0);
    random_phase(CAP_W'(3), 50, 6, 1'b0);
    random_phase(CAP_W'(0), 30, 8, 1'b0);
    random_phase(CAP_W'(16), 60, 20, 1'b0);
    random_phase(CAP_W'(2), 40, 10, 1'b1);
    random_phase(CAP_W'(8), 60, 12, 1'b0);
    random_phase(CAP_W'(16), 40, 18, 1'b0);

    drain();
    repeat (40) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
